@@ rtl/sha1he_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine package
// Shared types and constants for the SHA-1 hash engine: payload structs,
// control structs between the sequencer and its memories and round unit,
// and the algorithm constants.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    // Number of 32-bit words in the chaining state and the digest.
    localparam int unsigned HASH_WORDS = 5;
    // Number of compression rounds per block.
    localparam int unsigned NUM_ROUNDS = 80;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    // Byte that opens the message padding.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Per-block view of the block buffer: how many stored bytes are message
    // data, whether the pad byte follows them, and whether the bit length
    // fills the last eight bytes.
    typedef struct packed {
        logic [6:0] fill;
        logic       pad_en;
        logic       len_en;
    } t_blk_cfg;

    // Control of the round unit.
    typedef struct packed {
        logic       shift;      // shift working words, new word enters at e
        logic       rnd;        // run one compression round
        logic [6:0] round_idx;  // index of the round being run
    } t_core_ctl;

    // Initial chaining value.
    function automatic logic [31:0] h_init(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h67452301;
            3'd1:    val = 32'hEFCDAB89;
            3'd2:    val = 32'h98BADCFE;
            3'd3:    val = 32'h10325476;
            3'd4:    val = 32'hC3D2E1F0;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/sha1_hash_engine_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Streaming SHA-1: takes message bytes, compresses each 64-byte block, pads
// on the last transaction and returns the 160-bit digest as five words.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one byte
// per transaction; has_byte marks whether data_byte is a message byte, and
// last_byte ends the message. A transaction without a byte and without
// last_byte changes nothing. The output channel (o_out_valid / i_out_ready /
// o_out_data) returns the digest as five transactions, word 0 first, with
// last_word set on word 4.
// Bytes are taken one per cycle while a block fills. The byte that
// completes a block starts a compression (loading the chaining state from
// its memory, 80 rounds of the single round unit, then the add and write
// back). The last transaction adds one such compression, or
// two when fewer than nine bytes are left in the block, then reads out
// each digest word in turn.
// Input is taken only while the engine is idle. If the receiver stalls, the
// current digest word holds in the output register until taken.
// Reset empties the message and restores the initial chaining state;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  sha1he_pkg::t_in_item   i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output sha1he_pkg::t_out_item  o_out_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOADH = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADDH  = 3'd3;
    localparam logic [2:0] ST_EMRD  = 3'd4;
    localparam logic [2:0] ST_EMLD  = 3'd5;
    localparam logic [2:0] ST_EMWT  = 3'd6;

    // Kind of block being compressed.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PAD1  = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    localparam logic [6:0] LAST_ROUND = 7'(sha1he_pkg::NUM_ROUNDS - 1);
    localparam logic [6:0] HSEQ_END   = 7'(sha1he_pkg::HASH_WORDS);
    localparam logic [2:0] LAST_WORD  = 3'(sha1he_pkg::HASH_WORDS - 1);

    logic [2:0]            r_state, n_state;
    logic [6:0]            r_cnt, n_cnt;
    logic [63:0]           r_len, n_len;
    logic [1:0]            r_kind, n_kind;
    logic                  r_last_pend, n_last_pend;
    sha1he_pkg::t_blk_cfg  r_cfg, n_cfg;
    logic [2:0]            r_widx, n_widx;
    logic                  r_ovalid, n_ovalid;
    sha1he_pkg::t_out_item r_out, n_out;

    logic                  in_acc;
    logic                  go_final;
    logic [5:0]            fin_pos;
    logic                  buf_wr_en;
    logic [3:0]            buf_rd_addr;
    logic [31:0]           buf_word;
    logic [2:0]            h_rd_addr;
    logic                  h_wr_en;
    logic [2:0]            h_wr_addr;
    logic [31:0]           h_wr_data;
    logic [31:0]           h_rd_data;
    logic                  h_clear;
    logic [63:0]           bit_len;
    logic [31:0]           core_a;
    sha1he_pkg::t_core_ctl core_ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign bit_len    = {r_len[60:0], 3'b000};

    // Block buffer reads word 0 ahead of the first round, then one word ahead.
    assign buf_rd_addr = (r_state == ST_ROUND) ? (r_cnt[3:0] + 4'd1) : 4'd0;
    assign buf_wr_en   = in_acc && i_in_data.has_byte;

    // Chaining state read address follows the sequence counter or word index.
    always_comb begin
        if ((r_state == ST_EMRD) || (r_state == ST_EMLD) || (r_state == ST_EMWT)) begin
            h_rd_addr = r_widx;
        end else if (r_cnt < HSEQ_END) begin
            h_rd_addr = r_cnt[2:0];
        end else begin
            h_rd_addr = 3'd0;
        end
    end

    // Write-back: entry k-1 is written while entry k is read, so no entry is
    // read and written in overlapping cycles.
    assign h_wr_en   = (r_state == ST_ADDH) && (r_cnt != 7'd0);
    assign h_wr_addr = r_cnt[2:0] - 3'd1;
    assign h_wr_data = h_rd_data + core_a;

    // Round unit control.
    always_comb begin
        core_ctl.shift     = ((r_state == ST_LOADH) || (r_state == ST_ADDH)) &&
                             (r_cnt != 7'd0);
        core_ctl.rnd       = (r_state == ST_ROUND);
        core_ctl.round_idx = r_cnt;
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_kind      = r_kind;
        n_last_pend = r_last_pend;
        n_cfg       = r_cfg;
        n_widx      = r_widx;
        n_ovalid    = r_ovalid;
        n_out       = r_out;
        h_clear     = 1'b0;
        go_final    = 1'b0;
        fin_pos     = r_len[5:0];

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.has_byte) begin
                        n_len = r_len + 64'd1;
                    end
                    if (i_in_data.has_byte && (r_len[5:0] == 6'd63)) begin
                        // Buffer full: compress it, pad afterwards if last.
                        n_cfg.fill   = 7'd64;
                        n_cfg.pad_en = 1'b0;
                        n_cfg.len_en = 1'b0;
                        n_kind       = KIND_DATA;
                        n_last_pend  = i_in_data.last_byte;
                        n_cnt        = '0;
                        n_state      = ST_LOADH;
                    end else if (i_in_data.last_byte) begin
                        go_final = 1'b1;
                        fin_pos  = i_in_data.has_byte ? (r_len[5:0] + 6'd1) : r_len[5:0];
                    end
                end
            end
            ST_LOADH: begin
                if (r_cnt == HSEQ_END) begin
                    n_cnt   = '0;
                    n_state = ST_ROUND;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_ROUND: begin
                if (r_cnt == LAST_ROUND) begin
                    n_cnt   = '0;
                    n_state = ST_ADDH;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_ADDH: begin
                if (r_cnt == HSEQ_END) begin
                    n_cnt = '0;
                    case (r_kind)
                        KIND_DATA: begin
                            if (r_last_pend) begin
                                n_last_pend = 1'b0;
                                go_final    = 1'b1;
                                fin_pos     = r_len[5:0];
                            end else begin
                                n_state = ST_IDLE;
                            end
                        end
                        KIND_PAD1: begin
                            // Second padding block: zeros and the bit length.
                            n_cfg.fill   = 7'd0;
                            n_cfg.pad_en = 1'b0;
                            n_cfg.len_en = 1'b1;
                            n_kind       = KIND_FINAL;
                            n_state      = ST_LOADH;
                        end
                        default: begin
                            n_widx  = '0;
                            n_state = ST_EMRD;
                        end
                    endcase
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            ST_EMRD: begin
                n_state = ST_EMLD;
            end
            ST_EMLD: begin
                n_out.digest_word = h_rd_data;
                n_out.word_index  = r_widx;
                n_out.last_word   = (r_widx == LAST_WORD);
                n_ovalid          = 1'b1;
                n_state           = ST_EMWT;
            end
            ST_EMWT: begin
                if (i_out_ready) begin
                    n_ovalid = 1'b0;
                    if (r_widx == LAST_WORD) begin
                        // Digest delivered: start a fresh message.
                        h_clear = 1'b1;
                        n_len   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_widx  = r_widx + 3'd1;
                        n_state = ST_EMRD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Start padding: one block if the bit length still fits after the
        // pad byte, two blocks otherwise.
        if (go_final) begin
            n_cfg.fill   = {1'b0, fin_pos};
            n_cfg.pad_en = 1'b1;
            n_cfg.len_en = (fin_pos < 6'd56);
            n_kind       = (fin_pos < 6'd56) ? KIND_FINAL : KIND_PAD1;
            n_cnt        = '0;
            n_state      = ST_LOADH;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_len       <= '0;
            r_kind      <= KIND_DATA;
            r_last_pend <= 1'b0;
            r_widx      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_len       <= n_len;
            r_kind      <= n_kind;
            r_last_pend <= n_last_pend;
            r_widx      <= n_widx;
            r_ovalid    <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    sha1he_buf u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (buf_wr_en),
        .i_wr_pos  (r_len[5:0]),
        .i_wr_byte (i_in_data.data_byte),
        .i_rd_addr (buf_rd_addr),
        .i_cfg     (r_cfg),
        .i_bit_len (bit_len),
        .o_word    (buf_word)
    );

    sha1he_hmem u_hmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (h_clear),
        .i_rd_addr (h_rd_addr),
        .i_wr_en   (h_wr_en),
        .i_wr_addr (h_wr_addr),
        .i_wr_data (h_wr_data),
        .o_rd_data (h_rd_data)
    );

    sha1he_core u_core (
        .i_clk      (i_clk),
        .i_ctl      (core_ctl),
        .i_h_word   (h_rd_data),
        .i_buf_word (buf_word),
        .o_a        (core_a)
    );

    // A digest word is only presented while waiting in the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_state == ST_EMWT))
        else $error("output valid outside the digest output state");

    // The round counter never runs past the last round.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_cnt <= LAST_ROUND))
        else $error("round counter out of range");

    // The last-word flag marks exactly the final digest word.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out.last_word == (r_out.word_index == LAST_WORD)))
        else $error("last_word does not match word_index");

    // After the final word is taken, the byte count restarts from zero.
    a_len_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_ready && r_out.last_word) |=> (r_len == 64'd0))
        else $error("message length not cleared after digest");

endmodule

@@ rtl/sha1he_buf.sv @@
// ----------------------------------------------------------------------------
// SHA-1 block buffer
// Sixteen 32-bit words holding the current 64-byte block, written one byte
// at a time. The registered read word is shaped for the final blocks: bytes
// past the message fill read as the pad byte or zero, and the last two words
// can carry the message bit length.
// ----------------------------------------------------------------------------
module sha1he_buf (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [5:0]            i_wr_pos,
    input  logic [7:0]            i_wr_byte,
    input  logic [3:0]            i_rd_addr,
    input  sha1he_pkg::t_blk_cfg  i_cfg,
    input  logic [63:0]           i_bit_len,
    output logic [31:0]           o_word
);

    logic [31:0] r_mem [0:15];
    logic [31:0] r_q;
    logic [3:0]  r_q_addr;
    logic [1:0]  wr_lane;
    logic [6:0]  byte_pos;

    // Byte zero of a word sits in its most significant lane.
    assign wr_lane = ~i_wr_pos[1:0];

    // Byte write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_pos[5:2]][{wr_lane, 3'b000} +: 8] <= i_wr_byte;
        end
        r_q      <= r_mem[i_rd_addr];
        r_q_addr <= i_rd_addr;
    end

    // Shape the read word: message data, pad byte, zeros, then bit length.
    always_comb begin
        byte_pos = '0;
        o_word   = '0;
        for (int j = 0; j < 4; j++) begin
            byte_pos = {1'b0, r_q_addr, 2'(j)};
            if (byte_pos < i_cfg.fill) begin
                o_word[8*(3-j) +: 8] = r_q[8*(3-j) +: 8];
            end else if (i_cfg.pad_en && (byte_pos == i_cfg.fill)) begin
                o_word[8*(3-j) +: 8] = sha1he_pkg::PAD_BYTE;
            end else begin
                o_word[8*(3-j) +: 8] = 8'h00;
            end
        end
        if (i_cfg.len_en && (r_q_addr == 4'd14)) begin
            o_word = i_bit_len[63:32];
        end else if (i_cfg.len_en && (r_q_addr == 4'd15)) begin
            o_word = i_bit_len[31:0];
        end
    end

endmodule

@@ rtl/sha1he_hmem.sv @@
// ----------------------------------------------------------------------------
// SHA-1 chaining state memory
// Five 32-bit words with a registered read. Each entry has a valid
// bit; an entry that is not valid reads as the SHA-1 initial value, so a
// reset or a finished digest restores the initial state.
// ----------------------------------------------------------------------------
module sha1he_hmem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic [2:0]  i_rd_addr,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_addr,
    input  logic [31:0] i_wr_data,
    output logic [31:0] o_rd_data
);

    localparam int unsigned Depth = sha1he_pkg::HASH_WORDS;

    logic [31:0]      r_mem [0:Depth-1];
    logic [Depth-1:0] r_valid;
    logic [31:0]      r_q;
    logic             r_q_valid;
    logic [2:0]       r_q_addr;

    // Storage and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q      <= r_mem[i_rd_addr];
        r_q_addr <= i_rd_addr;
    end

    // Valid bits: cleared at reset and when a message completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
        end else begin
            r_q_valid <= r_valid[i_rd_addr];
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_q_valid ? r_q : sha1he_pkg::h_init(r_q_addr);

endmodule

@@ rtl/sha1he_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Working words a to e and the sixteen-word message schedule window. Runs one
// compression round per cycle, and shifts the working words to load them
// from or return them to the chaining state memory.
// ----------------------------------------------------------------------------
module sha1he_core (
    input  logic                   i_clk,
    input  sha1he_pkg::t_core_ctl  i_ctl,
    input  logic [31:0]            i_h_word,
    input  logic [31:0]            i_buf_word,
    output logic [31:0]            o_a
);

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [0:15];
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] w_mix;
    logic [31:0] w_t;
    logic [31:0] t_val;

    // Round function and constant by round group.
    always_comb begin
        if (i_ctl.round_idx < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = sha1he_pkg::K_ROUND0;
        end else if (i_ctl.round_idx < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1he_pkg::K_ROUND1;
        end else if (i_ctl.round_idx < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = sha1he_pkg::K_ROUND2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1he_pkg::K_ROUND3;
        end
    end

    // Schedule word: block word for the first sixteen rounds, then expanded.
    assign w_mix = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_t   = (i_ctl.round_idx < 7'd16) ? i_buf_word : {w_mix[30:0], w_mix[31]};
    assign t_val = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_t;

    // Working words and schedule window.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= i_h_word;
        end else if (i_ctl.rnd) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= t_val;
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_t;
        end
    end

    assign o_a = r_a;

endmodule
